// ===== rtl/core/o2st_pkg.sv =====
`timescale 1ns / 1ps
package o2st_pkg;

  localparam int ByteW   = 8;
  localparam int GroupW  = 6;
  localparam int SymW    = 8;
  localparam int LimitW  = 10;
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam logic [LimitW-1:0] LIMIT_RESET = 10'd1023;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            final_res;
  } o2st_word_t;

  // Up to two results produced by one input byte
  typedef struct packed {
    logic [1:0] count;
    o2st_word_t w0;
    o2st_word_t w1;
  } o2st_res_t;

  // Map a 6-bit group onto the alphabet: interleaved lower/upper letters,
  // then digits, '-' and '~'
  function automatic logic [SymW-1:0] sym_of(input logic [GroupW-1:0] g);
    logic [SymW-1:0] s;
    logic [SymW-1:0] gx;
    gx = {2'b00, g};
    if (g < 6'd52) begin
      s = (g[0] ? 8'h41 : 8'h61) + {3'b000, g[5:1]};
    end else if (g < 6'd62) begin
      s = 8'h30 + (gx - 8'd52);
    end else if (g == 6'd62) begin
      s = 8'h2D;
    end else begin
      s = 8'h7E;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/o2st_in_if.sv =====
`timescale 1ns / 1ps
interface o2st_in_if;
  import o2st_pkg::*;

  logic            valid;
  logic            ready;
  logic [ByteW-1:0] data_byte;
  logic            last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/o2st_out_if.sv =====
`timescale 1ns / 1ps
interface o2st_out_if;
  import o2st_pkg::*;

  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            final_res;

  modport source (output valid, output symbol, output final_res, input ready);
  modport sink   (input valid, input symbol, input final_res, output ready);
endinterface

// ===== rtl/core/octets_to_six_bit_text.sv =====
`timescale 1ns / 1ps
// Path: the slicer is combinational and a byte's characters are registered in the
// four-word result queue when the byte is taken. Throughput: one byte per cycle
// while the queue has room; a byte yields up to two characters and one leaves per
// cycle while the sink is ready; the queue's single output port sets the rate.
// Reset: clears the leftover bits, character count, limit flag and queue, and
// sets max_chars to 1023.
module octets_to_six_bit_text (
  input  logic                         clk,
  input  logic                         rst,
  o2st_in_if.sink                      in_ch,
  o2st_out_if.source                   out_ch,
  input  logic                         cfg_wr_en,
  input  logic [o2st_pkg::LimitW-1:0]  cfg_wr_data
);
  import o2st_pkg::*;

  logic [LimitW-1:0] max_chars;
  logic              accept;
  logic              space;
  o2st_res_t         res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_chars <= cfg_wr_data;
    end
  end

  assign in_ch.ready = space;
  assign accept = in_ch.valid && in_ch.ready;

  o2st_slicer u_slicer (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .max_chars (max_chars),
    .res       (res)
  );

  o2st_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .res    (res),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/core/o2st_slicer.sv =====
`timescale 1ns / 1ps
module o2st_slicer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [o2st_pkg::ByteW-1:0]    data_byte,
  input  logic                          last_byte,
  input  logic [o2st_pkg::LimitW-1:0]   max_chars,
  output o2st_pkg::o2st_res_t           res
);
  import o2st_pkg::*;

  logic [3:0]        leftover_bits, leftover_bits_next;
  logic [2:0]        leftover_count, leftover_count_next;
  logic [LimitW-1:0] chars_emitted, chars_emitted_next;
  logic              limit_reached, limit_reached_next;

  logic [11:0]       acc;
  logic [GroupW-1:0] g0, g1;
  logic [3:0]        rem_bits;
  logic [2:0]        rem_count;
  logic [LimitW:0]   emitted_x, max_x, emitted_new;
  logic              room0, room1, has0, has1, limit_now, mark;

  always_comb begin
    acc = {leftover_bits, data_byte};
    case (leftover_count)
      3'd4: begin
        g0 = acc[11:6];
        g1 = acc[5:0];
        rem_bits = 4'd0;
        rem_count = 3'd0;
      end
      3'd2: begin
        g0 = acc[9:4];
        g1 = {acc[3:0], 2'b00};
        rem_bits = acc[3:0];
        rem_count = 3'd4;
      end
      default: begin
        g0 = acc[7:2];
        g1 = {acc[1:0], 4'b0000};
        rem_bits = {2'b00, acc[1:0]};
        rem_count = 3'd2;
      end
    endcase

    emitted_x = {1'b0, chars_emitted};
    max_x = {1'b0, max_chars};
    room0 = emitted_x < max_x;
    room1 = (emitted_x + 11'd1) < max_x;
    has0 = !limit_reached && room0;
    // second word: another full group, or the zero-padded flush on the last byte
    has1 = has0 && room1 && ((leftover_count == 3'd4) || last_byte);
    emitted_new = emitted_x + {10'd0, has0} + {10'd0, has1};
    limit_now = emitted_new >= max_x;
    mark = last_byte || limit_now;

    res.count = {1'b0, has0} + {1'b0, has1};
    res.w0.symbol = sym_of(g0);
    res.w0.final_res = has0 && !has1 && mark;
    res.w1.symbol = sym_of(g1);
    res.w1.final_res = has1 && mark;

    leftover_bits_next = leftover_bits;
    leftover_count_next = leftover_count;
    chars_emitted_next = chars_emitted;
    limit_reached_next = limit_reached;
    if (last_byte) begin
      leftover_bits_next = 4'd0;
      leftover_count_next = 3'd0;
      chars_emitted_next = '0;
      limit_reached_next = 1'b0;
    end else if (!limit_reached) begin
      chars_emitted_next = emitted_new[LimitW-1:0];
      if (limit_now) begin
        limit_reached_next = 1'b1;
        leftover_bits_next = 4'd0;
        leftover_count_next = 3'd0;
      end else begin
        leftover_bits_next = rem_bits;
        leftover_count_next = rem_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits <= 4'd0;
      leftover_count <= 3'd0;
      chars_emitted <= '0;
      limit_reached <= 1'b0;
    end else if (accept) begin
      leftover_bits <= leftover_bits_next;
      leftover_count <= leftover_count_next;
      chars_emitted <= chars_emitted_next;
      limit_reached <= limit_reached_next;
    end
  end

endmodule

// ===== rtl/core/o2st_outq.sv =====
`timescale 1ns / 1ps
module o2st_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  o2st_pkg::o2st_res_t res,
  output logic                space,
  o2st_out_if.source          out_ch
);
  import o2st_pkg::*;

  o2st_word_t        entries [QDepth];
  logic [QPtrW-1:0]  wr_ptr, rd_ptr;
  logic [QCntW-1:0]  count, count_next;
  logic [1:0]        n_push;
  logic              pop;

  assign n_push = push ? res.count : 2'd0;
  assign pop = out_ch.valid && out_ch.ready;
  assign count_next = count + QCntW'(n_push) - QCntW'(pop);

  // room for two words, so one byte fits whatever it yields
  assign space = count <= QCntW'(QDepth - 2);

  assign out_ch.valid = count != '0;
  assign out_ch.symbol = entries[rd_ptr].symbol;
  assign out_ch.final_res = entries[rd_ptr].final_res;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries[wr_ptr] <= res.w0;
    end
    if (n_push == 2'd2) begin
      entries[wr_ptr + QPtrW'(1)] <= res.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPtrW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      count <= count_next;
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import o2st_pkg::*;

  localparam int CYCLE_LIMIT = 800_000;
  localparam int RANDOM_BYTES = 1750;
  localparam logic [8*64-1:0] CHARSET =
    "aAbBcCdDeEfFgGhHiIjJkKlLmMnNoOpPqQrRsStTuUvVwWxXyYzZ0123456789-~";

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [LimitW-1:0] cfg_wr_data;

  o2st_in_if in_ch();
  o2st_out_if out_ch();

  octets_to_six_bit_text dut (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Encoder state mirrored from the block
  logic [LimitW-1:0] char_limit;
  logic [3:0]        held_bits;
  logic [2:0]        held_cnt;
  logic [LimitW-1:0] chars_out;
  logic              cut_off;

  o2st_word_t pending_chars[$];

  int errors;
  int bytes_sent;
  int random_bytes;
  int strings_done;
  int chars_checked;
  int limit_hits;
  int cycles;
  int out_hold;
  bit in_quiet;
  bit out_quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SymW-1:0] char_of(input logic [GroupW-1:0] g);
    return CHARSET[8*(63 - int'(g)) +: 8];
  endfunction

  function automatic void clear_string_state();
    held_bits = '0;
    held_cnt  = '0;
    chars_out = '0;
    cut_off   = 1'b0;
  endfunction

  // Work out the characters one accepted byte produces and queue them
  function automatic void encode_octet(input logic [7:0] b, input logic l);
    logic [11:0] acc;
    int nbits;
    int n;
    o2st_word_t w[2];
    n = 0;
    if (cut_off) begin
      if (l) clear_string_state();
      return;
    end
    acc = {held_bits, b};
    nbits = int'(held_cnt) + 8;
    while (nbits >= GroupW && chars_out < char_limit && n < 2) begin
      nbits -= GroupW;
      w[n].symbol = char_of(GroupW'(acc >> nbits));
      w[n].final_res = 1'b0;
      n++;
      chars_out++;
    end
    acc &= (12'd1 << nbits) - 12'd1;
    // pad a partial group with zeros on the final byte
    if (l && nbits > 0 && nbits < GroupW && chars_out < char_limit && n < 2) begin
      w[n].symbol = char_of(GroupW'(acc << (GroupW - nbits)));
      w[n].final_res = 1'b0;
      n++;
      chars_out++;
    end
    if (n > 0 && (l || chars_out >= char_limit)) w[n-1].final_res = 1'b1;
    if (l) begin
      clear_string_state();
    end else if (chars_out >= char_limit) begin
      cut_off   = 1'b1;
      held_bits = '0;
      held_cnt  = '0;
      limit_hits++;
    end else begin
      held_bits = acc[3:0];
      held_cnt  = 3'(nbits);
    end
    for (int i = 0; i < n; i++) pending_chars.push_back(w[i]);
  endfunction

  task automatic send_octet(input logic [7:0] b, input logic l);
    int gap;
    gap = in_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= l;
    do @(posedge clk); while (!in_ch.ready);
    encode_octet(b, l);
    bytes_sent++;
    if (l) strings_done++;
  endtask

  task automatic send_random_string(input int len, input bit terminate);
    for (int i = 0; i < len; i++)
      send_octet(8'($urandom), terminate && (i == len - 1));
  endtask

  // Drop valid, wait for every character, then give the block time to finish
  // bytes that produce nothing
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    char_limit = v;
  endtask

  // Sink side: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_hold > 0) begin
        out_ch.ready <= 1'b0;
        out_hold--;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else if (out_quiet || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        out_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  always @(posedge clk) begin : char_check
    o2st_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected word: symbol %h final_res %b", out_ch.symbol, out_ch.final_res);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_ch.symbol !== want.symbol) begin
          $error("symbol: expected %h actual %h", want.symbol, out_ch.symbol);
          errors++;
        end
        if (out_ch.final_res !== want.final_res) begin
          $error("final_res: expected %b actual %b", want.final_res, out_ch.final_res);
          errors++;
        end
      end
    end
  end

  // Strings ending with 0, 2 and 4 bits left over, at the reset limit
  task automatic test_plain_strings();
    send_octet(8'h00, 1'b1);
    send_octet(8'hFF, 1'b0);
    send_octet(8'hFF, 1'b1);
    send_octet(8'hA5, 1'b0);
    send_octet(8'h5A, 1'b0);
    send_octet(8'hC3, 1'b1);
    send_octet(8'hF0, 1'b1);
    send_octet(8'h0F, 1'b1);
    settle();
  endtask

  // Limit reached mid-string: rest of the string dropped, then state clears
  task automatic test_limit_cut();
    write_limit(10'd3);
    send_octet(8'h12, 1'b0);
    send_octet(8'h34, 1'b0);
    send_octet(8'h56, 1'b0);
    send_octet(8'h78, 1'b0);
    send_octet(8'h9A, 1'b1);
    settle();
  endtask

  task automatic test_limit_on_final();
    write_limit(10'd2);
    send_octet(8'hFF, 1'b1);
    settle();
    write_limit(10'd1);
    send_octet(8'h81, 1'b0);
    send_octet(8'h7E, 1'b1);
    settle();
  endtask

  task automatic test_zero_limit();
    write_limit(10'd0);
    send_octet(8'h55, 1'b0);
    send_octet(8'hAA, 1'b1);
    settle();
  endtask

  task automatic test_limit_lowered();
    write_limit(10'd1023);
    send_octet(8'h00, 1'b0);
    send_octet(8'hFF, 1'b0);
    send_octet(8'h3C, 1'b0);
    settle();
    write_limit(10'd2);
    send_octet(8'hC3, 1'b0);
    send_octet(8'h18, 1'b1);
    settle();
    write_limit(10'd1023);
    send_octet(8'h42, 1'b1);
    settle();
  endtask

  task automatic test_random_strings();
    int nstr;
    int len;
    int r;
    int start;
    logic [LimitW-1:0] lim;
    bit leave_open;
    while (random_bytes < RANDOM_BYTES) begin
      r = $urandom_range(0, 9);
      case (r)
        0, 1:    lim = 10'd1023;
        2:       lim = ($urandom_range(0, 3) == 0) ? 10'd0 : 10'd1;
        3:       lim = 10'd2;
        4, 5, 6: lim = 10'($urandom_range(1, 12));
        7, 8:    lim = 10'($urandom_range(13, 60));
        default: lim = 10'($urandom_range(1, 1023));
      endcase
      write_limit(lim);
      in_quiet  = ($urandom_range(0, 4) == 0);
      out_quiet = ($urandom_range(0, 4) == 0);
      nstr = $urandom_range(2, 6);
      start = bytes_sent;
      for (int s = 0; s < nstr; s++) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 8);
        else if (r < 95) len = $urandom_range(9, 24);
        else len = $urandom_range(25, 60);
        // sometimes leave the string open across the next limit change
        leave_open = (s == nstr - 1) && ($urandom_range(0, 4) == 0);
        send_random_string(len, !leave_open);
      end
      if (lim != 0) random_bytes += bytes_sent - start;
      settle();
    end
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
  endtask

  // Hold the sink off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    write_limit(10'd1023);
    in_quiet = 1'b1;
    out_hold = 150;
    for (int s = 0; s < 4; s++) send_random_string(10, 1'b1);
    in_quiet = 1'b0;
    settle();
  endtask

  initial begin
    int waited;
    errors = 0;
    bytes_sent = 0;
    random_bytes = 0;
    strings_done = 0;
    chars_checked = 0;
    limit_hits = 0;
    cycles = 0;
    out_hold = 0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    char_limit = LIMIT_RESET;
    clear_string_state();
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_strings();
    test_limit_cut();
    test_limit_on_final();
    test_zero_limit();
    test_limit_lowered();
    test_backpressure();
    test_random_strings();

    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_chars.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $error("%0d expected words never arrived", pending_chars.size());
      errors++;
    end
    $display("Sent %0d bytes in %0d strings, checked %0d characters, limit cut %0d strings",
             bytes_sent, strings_done, chars_checked, limit_hits);
    $display("Limits ranged over 0, 1 and up to 1023, with a 150-cycle sink stall");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
